@@ rtl/based_integer_literal_to_value_top_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the based integer literal converter
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef BASED_INTEGER_LITERAL_TO_VALUE_TOP_DEFINES_SVH
`define BASED_INTEGER_LITERAL_TO_VALUE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BIL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BIL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/bil_pkg.sv @@
// ----------------------------------------------------------------------------
// Based integer literal converter package
// Character codes, field widths and the digit decode shared by the modules.
// ----------------------------------------------------------------------------
package bil_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned RADIX_W = 5;
  localparam int unsigned DIGIT_W = 4;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

  localparam logic [DIGIT_W-1:0] EXP_BASE   = 4'd10;
  localparam logic [CHAR_W-1:0]  HEX_OFFSET = 8'd10;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_UC_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UC_F  = 8'h46;
  localparam logic [CHAR_W-1:0] CHAR_LC_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LC_F  = 8'h66;

  function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
    logic [DIGIT_W-1:0] d;
    d = '0;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      d = DIGIT_W'(c - CHAR_ZERO);
    end else if (c >= CHAR_LC_A && c <= CHAR_LC_F) begin
      d = DIGIT_W'(c - CHAR_LC_A + HEX_OFFSET);
    end else if (c >= CHAR_UC_A && c <= CHAR_UC_F) begin
      d = DIGIT_W'(c - CHAR_UC_A + HEX_OFFSET);
    end
    return d;
  endfunction

  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] b;
    b = r;
    if (r < RADIX_MIN) begin
      b = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      b = RADIX_MAX;
    end
    return b;
  endfunction

endpackage

@@ rtl/based_integer_literal_to_value_top.sv @@
// A character that is not the last one is folded in without stalling the input, one per cycle.
// The last character starts scaling: each exponent step multiplies in the MAC when the
// exponent is positive, and divides in the bit-serial divider when it is negative.
// Scaling stops when the exponent is used up or the value reaches zero, so at most
// VALUE_WIDTH divide steps occur; input is stalled until the beat is registered.
// Reset is asynchronous and clears the literal state; the radix resets to ten.
// ----------------------------------------------------------------------------
// Based integer literal converter
// Accumulates mantissa and exponent characters, then scales by the radix.
// ----------------------------------------------------------------------------
module based_integer_literal_to_value_top #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned EXP_WIDTH   = 10
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                radix_we_i,
  input  logic [bil_pkg::RADIX_W-1:0]         radix_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [bil_pkg::CHAR_W-1:0]          char_code_i,
  input  logic                                in_exponent_i,
  input  logic                                last_char_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [VALUE_WIDTH-1:0]       literal_value_o
);

  localparam int unsigned EXT_W = EXP_WIDTH + bil_pkg::DIGIT_W + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCALE,
    ST_DIVIDE
  } state_e;

  state_e                        state_q, state_d;
  logic [bil_pkg::RADIX_W-1:0]   radix_q, radix_d;
  logic [VALUE_WIDTH-1:0]        acc_q, acc_d;
  logic                          mant_neg_q, mant_neg_d;
  logic                          mant_started_q, mant_started_d;
  logic [EXP_WIDTH-1:0]          exp_q, exp_d;
  logic                          exp_neg_q, exp_neg_d;
  logic                          exp_started_q, exp_started_d;
  logic                          out_valid_q, out_valid_d;
  logic [VALUE_WIDTH-1:0]        out_data_q, out_data_d;

  logic                          accept;
  logic [bil_pkg::RADIX_W-1:0]   base;
  logic [bil_pkg::DIGIT_W-1:0]   digit;
  logic [VALUE_WIDTH-1:0]        mac_value;
  logic [bil_pkg::DIGIT_W-1:0]   mac_digit;
  logic                          mac_sub;
  logic [VALUE_WIDTH-1:0]        mac_result;
  logic [EXT_W-1:0]              exp_ext;
  logic [EXP_WIDTH-1:0]          exp_sat;
  logic [VALUE_WIDTH-1:0]        acc_mag;
  logic                          div_start;
  logic                          div_done;
  logic [VALUE_WIDTH-1:0]        div_quotient;

  assign accept = in_valid_i && (state_q == ST_IDLE);
  assign base   = bil_pkg::clamp_radix(radix_q);
  assign digit  = bil_pkg::digit_of(char_code_i);

  always_comb begin
    if (state_q == ST_IDLE) begin
      mac_value = mant_started_q ? acc_q : '0;
      mac_digit = digit;
      mac_sub   = mant_neg_q;
    end else begin
      mac_value = acc_q;
      mac_digit = '0;
      mac_sub   = 1'b0;
    end
  end

  bil_mac #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_bil_mac (
    .value_i (mac_value),
    .base_i  (base),
    .digit_i (mac_digit),
    .sub_i   (mac_sub),
    .result_o(mac_result)
  );

  always_comb begin
    exp_ext = (exp_started_q ? EXT_W'(exp_q) : '0) * EXT_W'(bil_pkg::EXP_BASE)
              + EXT_W'(digit);
    if (|exp_ext[EXT_W-1:EXP_WIDTH]) begin
      exp_sat = '1;
    end else begin
      exp_sat = exp_ext[EXP_WIDTH-1:0];
    end
  end

  assign acc_mag = acc_q[VALUE_WIDTH-1] ? (-acc_q) : acc_q;

  bil_divider #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_bil_divider (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(acc_mag),
    .divisor_i (base),
    .done_o    (div_done),
    .quotient_o(div_quotient)
  );

  always_comb begin
    state_d        = state_q;
    radix_d        = radix_we_i ? radix_i : radix_q;
    acc_d          = acc_q;
    mant_neg_d     = mant_neg_q;
    mant_started_d = mant_started_q;
    exp_d          = exp_q;
    exp_neg_d      = exp_neg_q;
    exp_started_d  = exp_started_q;
    out_valid_d    = out_valid_q && out_stall_i;
    out_data_d     = out_data_q;
    div_start      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (!in_exponent_i) begin
            acc_d          = mac_result;
            mant_started_d = 1'b1;
            if (!mant_started_q && char_code_i == bil_pkg::CHAR_MINUS) begin
              mant_neg_d = 1'b1;
            end
          end else begin
            exp_d         = exp_sat;
            exp_started_d = 1'b1;
            if (!exp_started_q && char_code_i == bil_pkg::CHAR_MINUS) begin
              exp_neg_d = 1'b1;
            end
          end
          if (last_char_i) begin
            state_d = ST_SCALE;
          end
        end
      end
      ST_SCALE: begin
        if (exp_q == '0 || acc_q == '0) begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_d    = 1'b1;
            out_data_d     = acc_q;
            acc_d          = '0;
            mant_neg_d     = 1'b0;
            mant_started_d = 1'b0;
            exp_d          = '0;
            exp_neg_d      = 1'b0;
            exp_started_d  = 1'b0;
            state_d        = ST_IDLE;
          end
        end else if (exp_neg_q) begin
          div_start = 1'b1;
          state_d   = ST_DIVIDE;
        end else begin
          acc_d = mac_result;
          exp_d = exp_q - EXP_WIDTH'(1);
        end
      end
      ST_DIVIDE: begin
        if (div_done) begin
          acc_d   = acc_q[VALUE_WIDTH-1] ? (-div_quotient) : div_quotient;
          exp_d   = exp_q - EXP_WIDTH'(1);
          state_d = ST_SCALE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      radix_q        <= bil_pkg::RADIX_RESET;
      acc_q          <= '0;
      mant_neg_q     <= 1'b0;
      mant_started_q <= 1'b0;
      exp_q          <= '0;
      exp_neg_q      <= 1'b0;
      exp_started_q  <= 1'b0;
      out_valid_q    <= 1'b0;
      out_data_q     <= '0;
    end else begin
      state_q        <= state_d;
      radix_q        <= radix_d;
      acc_q          <= acc_d;
      mant_neg_q     <= mant_neg_d;
      mant_started_q <= mant_started_d;
      exp_q          <= exp_d;
      exp_neg_q      <= exp_neg_d;
      exp_started_q  <= exp_started_d;
      out_valid_q    <= out_valid_d;
      out_data_q     <= out_data_d;
    end
  end

  assign in_stall_o      = (state_q != ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign literal_value_o = out_data_q;

endmodule

@@ rtl/bil_mac.sv @@
// ----------------------------------------------------------------------------
// Shared multiply-accumulate unit
// Computes value times base plus or minus one digit, wrapping at the width.
// ----------------------------------------------------------------------------
module bil_mac #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic [VALUE_WIDTH-1:0]          value_i,
  input  logic [bil_pkg::RADIX_W-1:0]     base_i,
  input  logic [bil_pkg::DIGIT_W-1:0]     digit_i,
  input  logic                            sub_i,
  output logic [VALUE_WIDTH-1:0]          result_o
);

  logic [VALUE_WIDTH-1:0] prod;

  always_comb begin
    prod = value_i * VALUE_WIDTH'(base_i);
    if (sub_i) begin
      result_o = prod - VALUE_WIDTH'(digit_i);
    end else begin
      result_o = prod + VALUE_WIDTH'(digit_i);
    end
  end

endmodule

@@ rtl/bil_divider.sv @@
// ----------------------------------------------------------------------------
// Radix divider
// Restoring divider of an unsigned magnitude by the base, one bit per cycle.
// ----------------------------------------------------------------------------
module bil_divider #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [VALUE_WIDTH-1:0]      dividend_i,
  input  logic [bil_pkg::RADIX_W-1:0] divisor_i,
  output logic                        done_o,
  output logic [VALUE_WIDTH-1:0]      quotient_o
);

  localparam int unsigned CNT_W = $clog2(VALUE_WIDTH + 1);
  localparam int unsigned REM_W = bil_pkg::RADIX_W - 1;

  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [CNT_W-1:0]               cnt_q, cnt_d;
  logic [VALUE_WIDTH-1:0]         quo_q, quo_d;
  logic [REM_W-1:0]               rem_q, rem_d;
  logic [bil_pkg::RADIX_W-1:0]    trial;
  logic                           fits;

  always_comb begin
    trial  = {rem_q, quo_q[VALUE_WIDTH-1]};
    fits   = (trial >= divisor_i);
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(VALUE_WIDTH);
      quo_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      quo_d = {quo_q[VALUE_WIDTH-2:0], fits};
      rem_d = fits ? REM_W'(trial - divisor_i) : REM_W'(trial);
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      quo_q  <= quo_d;
      rem_q  <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

@@ rtl/bil_checker.sv @@
// ----------------------------------------------------------------------------
// Port checker for the based integer literal converter
// Watches the top-level ports and is bound to every instance of the top level.
// ----------------------------------------------------------------------------
`include "based_integer_literal_to_value_top_defines.svh"

module bil_checker #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          last_char_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic signed [VALUE_WIDTH-1:0] literal_value_o
);

  `BIL_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(literal_value_o), "stalled output beat changed")

  `BIL_ASSERT_NXT(a_last_stalls, clk_i, rst_ni, in_valid_i && !in_stall_o && last_char_i, in_stall_o, "last character did not start scaling")

  `BIL_ASSERT_NXT(a_char_no_stall, clk_i, rst_ni, in_valid_i && !in_stall_o && !last_char_i, !in_stall_o, "inner character caused a stall")

  `BIL_ASSERT_IMP(a_done_has_beat, clk_i, rst_ni, $fell(in_stall_o), out_valid_o, "scaling ended without an output beat")

endmodule

bind based_integer_literal_to_value_top bil_checker #(
  .VALUE_WIDTH(VALUE_WIDTH)
) u_bil_checker (.*);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the based integer literal converter
// Sends literals one character per beat under random flow control on both
// sides. An in-bench converter predicts every value, and each output beat is
// compared with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CHAR_W        = bil_pkg::CHAR_W;
  localparam int unsigned RADIX_W       = bil_pkg::RADIX_W;
  localparam int unsigned VALUE_W       = 32;
  localparam int unsigned EXP_W         = 10;
  localparam int unsigned EXP_CEILING   = (1 << EXP_W) - 1;
  localparam int unsigned STALL_LIMIT   = 20000;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned PHASE_CHARS   = 200;
  localparam int unsigned REPORT_LIMIT  = 10;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              is_exp;
  } lit_char_t;

  logic                      clk         = 1'b0;
  logic                      rst_n       = 1'b0;
  logic                      radix_we    = 1'b0;
  logic [RADIX_W-1:0]        radix       = '0;
  logic                      in_valid    = 1'b0;
  logic                      in_stall;
  logic [CHAR_W-1:0]         char_code   = '0;
  logic                      in_exponent = 1'b0;
  logic                      last_char   = 1'b0;
  logic                      out_valid;
  logic                      out_stall   = 1'b0;
  logic signed [VALUE_W-1:0] literal_value;

  logic [RADIX_W-1:0] radix_model = bil_pkg::RADIX_RESET;
  logic [VALUE_W-1:0] value_acc   = '0;
  logic               mant_neg    = 1'b0;
  logic [1:0]         mant_pos    = '0;
  logic [EXP_W-1:0]   exp_acc     = '0;
  logic               exp_neg     = 1'b0;
  logic               exp_seen    = 1'b0;

  logic [VALUE_W-1:0] expected_values[$];
  logic [VALUE_W-1:0] oldest_value;
  int unsigned        mismatch_count = 0;
  int unsigned        quiet_cycles   = 0;
  int unsigned        hold_requests  = 0;
  bit                 calm           = 1'b0;

  based_integer_literal_to_value_top #(
    .VALUE_WIDTH(VALUE_W),
    .EXP_WIDTH  (EXP_W)
  ) u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .radix_we_i     (radix_we),
    .radix_i        (radix),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .char_code_i    (char_code),
    .in_exponent_i  (in_exponent),
    .last_char_i    (last_char),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .literal_value_o(literal_value)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [3:0] char_digit(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] d;
    d = '0;
    if (c >= bil_pkg::CHAR_ZERO && c <= bil_pkg::CHAR_NINE) begin
      d = c - bil_pkg::CHAR_ZERO;
    end else if (c >= bil_pkg::CHAR_LC_A && c <= bil_pkg::CHAR_LC_F) begin
      d = c - bil_pkg::CHAR_LC_A + 8'd10;
    end else if (c >= bil_pkg::CHAR_UC_A && c <= bil_pkg::CHAR_UC_F) begin
      d = c - bil_pkg::CHAR_UC_A + 8'd10;
    end
    return d[3:0];
  endfunction

  function automatic int unsigned scale_base();
    if (radix_model < bil_pkg::RADIX_MIN) begin
      return bil_pkg::RADIX_MIN;
    end else if (radix_model > bil_pkg::RADIX_MAX) begin
      return bil_pkg::RADIX_MAX;
    end
    return radix_model;
  endfunction

  // Folds one character into the literal; returns 1 with the value on the last one.
  function automatic bit fold_char(input logic [CHAR_W-1:0] c, input logic is_exp,
                                   input logic last, output logic [VALUE_W-1:0] value);
    logic [VALUE_W-1:0] base;
    logic [VALUE_W-1:0] digit;
    logic [VALUE_W-1:0] mag;
    int unsigned        e;
    int unsigned        i;
    base  = VALUE_W'(scale_base());
    digit = VALUE_W'(char_digit(c));
    value = '0;
    if (!is_exp) begin
      if (mant_pos == 2'd0) begin
        if (c == bil_pkg::CHAR_MINUS) begin
          mant_neg  = 1'b1;
          value_acc = '0;
        end else begin
          value_acc = digit;
        end
        mant_pos = 2'd1;
      end else begin
        value_acc = mant_neg ? value_acc * base - digit : value_acc * base + digit;
        mant_pos  = 2'd2;
      end
    end else if (!exp_seen) begin
      exp_seen = 1'b1;
      if (c == bil_pkg::CHAR_PLUS || c == bil_pkg::CHAR_MINUS) begin
        exp_neg = (c == bil_pkg::CHAR_MINUS);
        exp_acc = '0;
      end else begin
        exp_acc = EXP_W'(digit);
      end
    end else begin
      e       = exp_acc * bil_pkg::EXP_BASE + digit;
      exp_acc = (e > EXP_CEILING) ? EXP_W'(EXP_CEILING) : EXP_W'(e);
    end
    if (!last) begin
      return 1'b0;
    end
    for (i = 0; i < exp_acc && value_acc != '0; i++) begin
      if (exp_neg) begin
        mag       = value_acc[VALUE_W-1] ? -value_acc : value_acc;
        mag       = mag / base;
        value_acc = value_acc[VALUE_W-1] ? -mag : mag;
      end else begin
        value_acc = value_acc * base;
      end
    end
    value     = value_acc;
    value_acc = '0;
    mant_neg  = 1'b0;
    mant_pos  = '0;
    exp_acc   = '0;
    exp_neg   = 1'b0;
    exp_seen  = 1'b0;
    return 1'b1;
  endfunction

  task automatic send_char(input logic [CHAR_W-1:0] code, input logic is_exp,
                           input logic last);
    int unsigned        gap;
    logic [VALUE_W-1:0] value;
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    char_code   <= code;
    in_exponent <= is_exp;
    last_char   <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (fold_char(code, is_exp, last, value)) begin
      expected_values.push_back(value);
    end
  endtask

  task automatic send_text(input string mant, input string expo);
    int unsigned total;
    total = mant.len() + expo.len();
    for (int i = 0; i < mant.len(); i++) begin
      send_char(mant[i], 1'b0, i == total - 1);
    end
    for (int i = 0; i < expo.len(); i++) begin
      send_char(expo[i], 1'b1, mant.len() + i == total - 1);
    end
  endtask

  task automatic settle_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_values.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_radix(input logic [RADIX_W-1:0] value);
    settle_block();
    @(negedge clk);
    radix_we <= 1'b1;
    radix    <= value;
    @(negedge clk);
    radix_we    <= 1'b0;
    radix_model  = value;
  endtask

  function automatic logic [CHAR_W-1:0] digit_char(input int unsigned v);
    if (v < 10) begin
      return bil_pkg::CHAR_ZERO + CHAR_W'(v);
    end
    return ($urandom_range(0, 1) ? bil_pkg::CHAR_LC_A : bil_pkg::CHAR_UC_A)
           + CHAR_W'(v - 10);
  endfunction

  task automatic send_random_literal(inout int unsigned sent);
    lit_char_t   chars[$];
    lit_char_t   one;
    int unsigned n_mant;
    int unsigned n_exp;
    n_mant = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 12) : $urandom_range(1, 6);
    for (int i = 0; i < n_mant; i++) begin
      one.is_exp = 1'b0;
      if (i == 0 && $urandom_range(0, 2) == 0) begin
        one.code = bil_pkg::CHAR_MINUS;
      end else begin
        case ($urandom_range(0, 19))
          0:       one.code = CHAR_W'($urandom_range(0, 255));
          1, 2:    one.code = digit_char($urandom_range(0, 15));
          3:       one.code = $urandom_range(0, 1) ? bil_pkg::CHAR_PLUS
                                                   : bil_pkg::CHAR_MINUS;
          default: one.code = digit_char($urandom_range(0, scale_base() - 1));
        endcase
      end
      chars.push_back(one);
    end
    if ($urandom_range(0, 1) == 1) begin
      one.is_exp = 1'b1;
      if ($urandom_range(0, 1) == 1) begin
        one.code = $urandom_range(0, 1) ? bil_pkg::CHAR_PLUS : bil_pkg::CHAR_MINUS;
        chars.push_back(one);
      end
      n_exp = ($urandom_range(0, 19) == 0) ? $urandom_range(3, 5) : $urandom_range(0, 2);
      for (int i = 0; i < n_exp; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          one.code = CHAR_W'($urandom_range(0, 255));
        end else begin
          one.code = digit_char($urandom_range(0, 9));
        end
        chars.push_back(one);
      end
    end
    if (chars.size() == 0) begin
      one.is_exp = 1'b0;
      one.code   = digit_char($urandom_range(0, 15));
      chars.push_back(one);
    end
    foreach (chars[i]) begin
      if ($urandom_range(0, 24) == 0) begin
        chars[i].is_exp = !chars[i].is_exp;
      end
    end
    foreach (chars[i]) begin
      send_char(chars[i].code, chars[i].is_exp, i == chars.size() - 1);
      sent++;
    end
  endtask

  task automatic test_signs_and_digits();
    send_text("-", "");
    send_text("-9A", "-1");
    send_text("+F", "+");
    send_text("", "5");
  endtask

  task automatic test_exponent_saturation();
    send_char("1", 1'b0, 1'b0);
    send_char(bil_pkg::CHAR_MINUS, 1'b0, 1'b0);
    send_char("9", 1'b1, 1'b0);
    send_char(bil_pkg::CHAR_MINUS, 1'b1, 1'b0);
    send_char("9", 1'b1, 1'b0);
    send_char("9", 1'b1, 1'b0);
    send_char("3", 1'b0, 1'b1);
  endtask

  task automatic test_most_negative_division();
    write_radix(5'd31);
    send_text("-80000000", "-1");
  endtask

  task automatic test_backpressure();
    hold_requests++;
    send_text("12", "");
    send_text("-34", "+2");
    send_text("5", "-1");
    send_text("777", "");
  endtask

  task automatic test_random_phases();
    logic [RADIX_W-1:0] settings[10];
    int unsigned        sent;
    settings    = '{5'd10, 5'd2, 5'd16, 5'd0, 5'd1, 5'd17, 5'd31, 5'd3, 5'd7, 5'd0};
    settings[9] = RADIX_W'($urandom_range(0, 31));
    for (int p = 0; p < 10; p++) begin
      if (p == 9) begin
        calm = 1'b1;
      end
      write_radix(settings[p]);
      sent = 0;
      while (sent < PHASE_CHARS) begin
        send_random_literal(sent);
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_signs_and_digits();
    test_exponent_saturation();
    test_most_negative_division();
    test_backpressure();
    test_random_phases();
    settle_block();
    if (mismatch_count == 0) begin
      $display("based_integer_literal_to_value_top test passed");
    end else begin
      $display("based_integer_literal_to_value_top test failed");
    end
    $finish;
  end

  initial begin : receiver_flow
    int unsigned burst;
    int unsigned quiet;
    int unsigned hold_left;
    int unsigned holds_served;
    burst        = 0;
    quiet        = 0;
    hold_left    = 0;
    holds_served = 0;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (holds_served != hold_requests) begin
        holds_served++;
        hold_left  = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else if (calm || quiet != 0) begin
        if (quiet != 0) begin
          quiet--;
        end
        out_stall <= 1'b0;
      end else if (burst != 0) begin
        burst--;
        out_stall <= 1'b1;
      end else begin
        case ($urandom_range(0, 29))
          0: begin
            quiet      = $urandom_range(20, 60);
            out_stall <= 1'b0;
          end
          1, 2, 3, 4, 5: begin
            burst      = $urandom_range(0, 7);
            out_stall <= 1'b1;
          end
          default: out_stall <= 1'b0;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_values.size() == 0) begin
        if (mismatch_count < REPORT_LIMIT) begin
          $display("unexpected output beat: literal_value %0d", literal_value);
        end
        mismatch_count++;
      end else begin
        oldest_value = expected_values.pop_front();
        if (literal_value !== oldest_value) begin
          if (mismatch_count < REPORT_LIMIT) begin
            $display("literal_value mismatch: expected %0d, got %0d",
                     $signed(oldest_value), literal_value);
          end
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("based_integer_literal_to_value_top test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
